### src/dfr_pkg.sv
`default_nettype none

package dfr_pkg;

  // Default bounds
  localparam int unsigned MAX_NAME_LEN_DEF = 255;
  localparam int unsigned LEN_BITS_DEF     = 31;

  // Character constants
  localparam logic [7:0] CHAR_0 = 8'h30;
  localparam logic [7:0] CHAR_9 = 8'h39;

  // Input function codes
  localparam logic [1:0] FUNC_DATA = 2'd0;
  localparam logic [1:0] FUNC_EOS  = 2'd1;
  localparam logic [1:0] FUNC_NEW  = 2'd2;

  // Byte classes
  localparam logic [2:0] CL_HDR   = 3'd0;
  localparam logic [2:0] CL_NAME  = 3'd1;
  localparam logic [2:0] CL_PAY   = 3'd2;
  localparam logic [2:0] CL_ABORT = 3'd3;
  localparam logic [2:0] CL_FIN   = 3'd4;

  localparam int unsigned BYTES_LEFT_W = 31;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] byte_value;
  } in_t;

  typedef struct packed {
    logic [2:0]              byte_class;
    logic [7:0]              data_out;
    logic                    last_in_field;
    logic [BYTES_LEFT_W-1:0] bytes_left;
  } out_t;

endpackage

`default_nettype wire

### src/length_prefixed_file_deframer_unit.sv
// Length-prefixed file deframer, one byte per transfer.
//
// Input channel (in_valid_i / in_ready_o / in_item_i): each transfer carries
// a function code and a byte: a data byte, an early end of stream, or a new
// connection that clears the parser.
// Output channel (out_valid_o / out_ready_i / out_item_o): exactly one result
// per input transfer, in order: byte class, echoed byte, last-in-field flag
// and the payload bytes still expected.
//
// Datapath: input register -> parser (state plus short next-state logic,
// times-ten adds and compares for the two length fields) -> output register.
// A byte taken at the input waits in the input register, then passes
// through the combinational parser into the output register.
// Throughput: one byte per cycle unless the receiver stalls.
//
// Reset (rst_ni low, async): both registers empty, parser back to the
// name length phase with all counts cleared.
// Receiver stall: the output register holds its result; the input register
// keeps the next byte and in_ready_o drops only when both are full, so no
// transfer is lost and no bubble is added once the stall ends.
`default_nettype none

module length_prefixed_file_deframer_unit import dfr_pkg::*; #(
  parameter int unsigned MAX_NAME_LEN = MAX_NAME_LEN_DEF,
  parameter int unsigned LEN_BITS     = LEN_BITS_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire in_t  in_item_i,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output out_t      out_item_o
);

  logic in_valid_q;
  in_t  in_item_q;
  logic res_ready;
  out_t result;

  // input stage
  dfr_pipe_reg #(.T(in_t)) u_in_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_item_i),
    .out_valid_o (in_valid_q),
    .out_ready_i (res_ready),
    .out_data_o  (in_item_q)
  );

  // parser advances only when its result moves into the output stage
  dfr_parser #(
    .MAX_NAME_LEN (MAX_NAME_LEN),
    .LEN_BITS     (LEN_BITS)
  ) u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (in_valid_q && res_ready),
    .item_i   (in_item_q),
    .result_o (result)
  );

  // output stage
  dfr_pipe_reg #(.T(out_t)) u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_q),
    .in_ready_o  (res_ready),
    .in_data_i   (result),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_item_o)
  );

endmodule

`default_nettype wire

### src/dfr_pipe_reg.sv
`default_nettype none

module dfr_pipe_reg import dfr_pkg::*; #(
  parameter type T = in_t
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire T     in_data_i,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output T          out_data_o
);

  logic valid_q;
  T     data_q;

  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  // payload: no reset
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      data_q <= in_data_i;
    end
  end

endmodule

`default_nettype wire

### src/dfr_parser.sv
`default_nettype none

module dfr_parser import dfr_pkg::*; #(
  parameter int unsigned MAX_NAME_LEN = MAX_NAME_LEN_DEF,
  parameter int unsigned LEN_BITS     = LEN_BITS_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic fire_i,
  input  wire in_t  item_i,
  output out_t      result_o
);

  localparam int unsigned NL_W  = $clog2(MAX_NAME_LEN + 1);
  localparam int unsigned NA_W  = NL_W + 4;
  localparam int unsigned PA_W  = LEN_BITS + 4;

  localparam logic [NA_W-1:0] NAME_MAX = NA_W'(MAX_NAME_LEN);
  localparam logic [PA_W-1:0] PAY_MAX  = {4'b0000, {LEN_BITS{1'b1}}};

  typedef enum logic [2:0] {
    PH_NLEN,
    PH_NAME,
    PH_SEP,
    PH_PLEN,
    PH_PAY,
    PH_TRAIL,
    PH_IDLE
  } phase_e;

  phase_e              phase_q, phase_d;
  logic [NL_W-1:0]     name_length_q, name_length_d;
  logic [NL_W-1:0]     name_count_q, name_count_d;
  logic                first_zero_q, first_zero_d;
  logic [LEN_BITS-1:0] pay_rem_q, pay_rem_d;

  logic            digit;
  logic [7:0]      diff;
  logic [3:0]      dval;
  logic [NA_W-1:0] nl_ext, nl_acc;
  logic [PA_W-1:0] pr_ext, pr_acc;
  logic [NL_W-1:0] cnt_inc;
  logic            fz;
  logic [LEN_BITS-1:0] pr_dec;

  assign digit = (item_i.byte_value >= CHAR_0) && (item_i.byte_value <= CHAR_9);
  assign diff  = item_i.byte_value - CHAR_0;
  assign dval  = diff[3:0];

  // x*10 + d as shifts and adds
  assign nl_ext = {4'b0000, name_length_q};
  assign nl_acc = (nl_ext << 3) + (nl_ext << 1) + {{(NA_W-4){1'b0}}, dval};
  assign pr_ext = {4'b0000, pay_rem_q};
  assign pr_acc = (pr_ext << 3) + (pr_ext << 1) + {{(PA_W-4){1'b0}}, dval};

  assign cnt_inc = name_count_q + NL_W'(1);
  assign fz      = first_zero_q || ((name_count_q == '0) && (item_i.byte_value == 8'h00));
  assign pr_dec  = (pay_rem_q != '0) ? pay_rem_q - LEN_BITS'(1) : pay_rem_q;

  always_comb begin
    phase_d       = phase_q;
    name_length_d = name_length_q;
    name_count_d  = name_count_q;
    first_zero_d  = first_zero_q;
    pay_rem_d     = pay_rem_q;
    result_o      = '0;
    result_o.byte_class = CL_HDR;

    case (item_i.func)
      FUNC_NEW: begin
        phase_d       = PH_NLEN;
        name_length_d = '0;
        name_count_d  = '0;
        first_zero_d  = 1'b0;
        pay_rem_d     = '0;
      end
      FUNC_EOS: begin
        if (phase_q != PH_IDLE) begin
          result_o.byte_class = CL_ABORT;
          phase_d = PH_IDLE;
        end
      end
      FUNC_DATA: begin
        case (phase_q)
          PH_NLEN: begin
            if (digit) begin
              if (nl_acc > NAME_MAX) begin
                result_o.byte_class = CL_ABORT;
                phase_d = PH_IDLE;
              end else begin
                name_length_d = nl_acc[NL_W-1:0];
              end
            end else if (name_length_q == '0) begin
              result_o.byte_class = CL_ABORT;
              phase_d = PH_IDLE;
            end else begin
              name_count_d = '0;
              first_zero_d = 1'b0;
              phase_d      = PH_NAME;
            end
          end
          PH_NAME: begin
            first_zero_d = fz;
            name_count_d = cnt_inc;
            if (cnt_inc >= name_length_q) begin
              if (fz) begin
                result_o.byte_class = CL_ABORT;
                phase_d = PH_IDLE;
              end else begin
                result_o.byte_class    = CL_NAME;
                result_o.data_out      = item_i.byte_value;
                result_o.last_in_field = 1'b1;
                phase_d = PH_SEP;
              end
            end else begin
              result_o.byte_class = CL_NAME;
              result_o.data_out   = item_i.byte_value;
            end
          end
          PH_SEP: begin
            pay_rem_d = '0;
            phase_d   = PH_PLEN;
          end
          PH_PLEN: begin
            if (digit) begin
              if (pr_acc > PAY_MAX) begin
                result_o.byte_class = CL_ABORT;
                phase_d = PH_IDLE;
              end else begin
                pay_rem_d = pr_acc[LEN_BITS-1:0];
              end
            end else if (pay_rem_q == '0) begin
              result_o.byte_class = CL_ABORT;
              phase_d = PH_IDLE;
            end else begin
              phase_d = PH_PAY;
            end
          end
          PH_PAY: begin
            result_o.byte_class = CL_PAY;
            result_o.data_out   = item_i.byte_value;
            result_o.bytes_left = BYTES_LEFT_W'(pr_dec);
            pay_rem_d = pr_dec;
            if (pr_dec == '0) begin
              result_o.last_in_field = 1'b1;
              phase_d = PH_TRAIL;
            end
          end
          PH_TRAIL: begin
            result_o.byte_class = CL_FIN;
            phase_d = PH_IDLE;
          end
          default: begin
            phase_d = PH_IDLE;
          end
        endcase
      end
      default: begin
        // unused code: no change
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_NLEN;
      name_length_q <= '0;
      name_count_q  <= '0;
      first_zero_q  <= 1'b0;
      pay_rem_q     <= '0;
    end else if (fire_i) begin
      phase_q       <= phase_d;
      name_length_q <= name_length_d;
      name_count_q  <= name_count_d;
      first_zero_q  <= first_zero_d;
      pay_rem_q     <= pay_rem_d;
    end
  end

endmodule

`default_nettype wire

### dv/dfr_checker.sv
module dfr_checker import dfr_pkg::*; #(
  parameter int unsigned MAX_NAME_LEN = MAX_NAME_LEN_DEF,
  parameter int unsigned LEN_BITS     = LEN_BITS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic in_ready_i,
  input  in_t  in_item_i,
  input  logic out_valid_i,
  input  logic out_ready_i,
  input  out_t out_item_i,
  output int   errors_o,
  output int   pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [2:0] {
    PH_NAME_LEN, PH_NAME, PH_SEP, PH_PAY_LEN, PH_PAYLOAD, PH_TRAIL, PH_DONE
  } phase_e;

  localparam logic [63:0] PAY_MAX = (64'd1 << LEN_BITS) - 64'd1;

  phase_e      phase;
  int unsigned name_len;
  int unsigned name_seen;
  bit          lead_zero;
  logic [63:0] pay_left;

  out_t parsed_q[$];
  out_t oldest;
  int   errors = 0;

  function automatic void clear_parser();
    phase     = PH_NAME_LEN;
    name_len  = 0;
    name_seen = 0;
    lead_zero = 1'b0;
    pay_left  = '0;
  endfunction

  // One byte through the frame parser; returns its classification.
  function automatic out_t parse_byte(in_t it);
    out_t        r;
    logic [7:0]  b;
    int unsigned d;
    bit          is_digit;
    r        = '0;
    b        = it.byte_value;
    is_digit = (b >= CHAR_0) && (b <= CHAR_9);
    d        = b - CHAR_0;
    r.byte_class = CL_HDR;
    case (it.func)
      FUNC_NEW: clear_parser();
      FUNC_EOS: begin
        if (phase != PH_DONE) begin
          r.byte_class = CL_ABORT;
          phase = PH_DONE;
        end
      end
      FUNC_DATA: begin
        case (phase)
          PH_NAME_LEN: begin
            if (is_digit) begin
              if (d > MAX_NAME_LEN || name_len > (MAX_NAME_LEN - d) / 10) begin
                r.byte_class = CL_ABORT;
                phase = PH_DONE;
              end else begin
                name_len = name_len * 10 + d;
              end
            end else if (name_len == 0) begin
              r.byte_class = CL_ABORT;
              phase = PH_DONE;
            end else begin
              name_seen = 0;
              lead_zero = 1'b0;
              phase = PH_NAME;
            end
          end
          PH_NAME: begin
            if (name_seen == 0 && b == 8'h00) lead_zero = 1'b1;
            name_seen++;
            if (name_seen >= name_len) begin
              if (lead_zero) begin
                r.byte_class = CL_ABORT;
                phase = PH_DONE;
              end else begin
                r.byte_class    = CL_NAME;
                r.data_out      = b;
                r.last_in_field = 1'b1;
                phase = PH_SEP;
              end
            end else begin
              r.byte_class = CL_NAME;
              r.data_out   = b;
            end
          end
          PH_SEP: begin
            pay_left = '0;
            phase = PH_PAY_LEN;
          end
          PH_PAY_LEN: begin
            if (is_digit) begin
              if (pay_left > (PAY_MAX - 64'(d)) / 10) begin
                r.byte_class = CL_ABORT;
                phase = PH_DONE;
              end else begin
                pay_left = pay_left * 10 + 64'(d);
              end
            end else if (pay_left == 0) begin
              r.byte_class = CL_ABORT;
              phase = PH_DONE;
            end else begin
              phase = PH_PAYLOAD;
            end
          end
          PH_PAYLOAD: begin
            r.byte_class = CL_PAY;
            r.data_out   = b;
            if (pay_left > 0) pay_left--;
            r.bytes_left = pay_left[BYTES_LEFT_W-1:0];
            if (pay_left == 0) begin
              r.last_in_field = 1'b1;
              phase = PH_TRAIL;
            end
          end
          PH_TRAIL: begin
            r.byte_class = CL_FIN;
            phase = PH_DONE;
          end
          default: phase = PH_DONE;
        endcase
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic note_mismatch(string what, out_t want, out_t got);
    errors++;
    if (errors <= 10)
      $display("%0t %s: exp class %0d data %02h last %0d left %0d, got class %0d data %02h last %0d left %0d",
               $realtime, what, want.byte_class, want.data_out, want.last_in_field,
               want.bytes_left, got.byte_class, got.data_out, got.last_in_field, got.bytes_left);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_parser();
      parsed_q.delete();
    end else begin
      // Retire results before queuing the model result for new input.
      if (out_valid_i && out_ready_i) begin
        if (parsed_q.size() == 0) begin
          note_mismatch("unexpected result", '0, out_item_i);
        end else begin
          oldest = parsed_q.pop_front();
          if (oldest.byte_class !== out_item_i.byte_class ||
              oldest.data_out !== out_item_i.data_out ||
              oldest.last_in_field !== out_item_i.last_in_field ||
              oldest.bytes_left !== out_item_i.bytes_left)
            note_mismatch("result mismatch", oldest, out_item_i);
        end
      end
      if (in_valid_i && in_ready_i) parsed_q.push_back(parse_byte(in_item_i));
    end
    pending_o = parsed_q.size();
    errors_o  = errors;
  end

endmodule

### dv/tb_length_prefixed_file_deframer_unit.sv
module tb_length_prefixed_file_deframer_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import dfr_pkg::*;

  // func 3 has no meaning in the block; it must change nothing
  localparam logic [1:0] FUNC_RSVD = 2'd3;
  localparam longint unsigned PAY_MAX = (64'd1 << LEN_BITS_DEF) - 1;
  // Cycles without any transfer before the run is declared hung. The worst
  // legal gap is a sender burst plus a receiver burst plus the pipeline.
  localparam int STALL_LIMIT = 2000;
  localparam int N_ITEMS     = 1900;
  localparam int CALM_AFTER  = 1650;   // no random gaps or stalls past this many transfers

  logic clk_i = 1'b0;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  in_t  in_item_i;
  logic out_valid_o;
  logic out_ready_i;
  out_t out_item_o;

  int errors;
  int pending;
  int sent_count = 0;
  int gap_pct    = 15;   // chance per transfer that the sender goes quiet
  int stall_pct  = 15;   // chance per cycle that the receiver stalls
  int idle_cycles = 0;

  in_t frame_q[$];

  length_prefixed_file_deframer_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  dfr_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_i  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_i (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_i  (out_item_o),
    .errors_o    (errors),
    .pending_o   (pending)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Receiver: random stall bursts, changed at the falling edge.
  always begin
    @(negedge clk_i);
    if (rst_ni && $urandom_range(1, 100) <= stall_pct) begin
      out_ready_i <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk_i);
      out_ready_i <= 1'b1;
    end
  end

  // Hang detection: any transfer on either channel resets the count.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
          $display("length_prefixed_file_deframer_unit test failed");
          $finish;
        end
      end
    end
  end

  function automatic in_t mk(logic [1:0] f, logic [7:0] b);
    in_t it;
    it.func       = f;
    it.byte_value = b;
    return it;
  endfunction

  function automatic logic [7:0] non_digit();
    logic [7:0] b;
    do b = 8'($urandom); while (b >= CHAR_0 && b <= CHAR_9);
    return b;
  endfunction

  // Called at a falling edge. Holds valid until the transfer, then maybe
  // goes quiet for a burst. Valid stays high across back-to-back transfers.
  task automatic send_item(in_t it);
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sent_count++;
    @(negedge clk_i);
    if ($urandom_range(1, 100) <= gap_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk_i);
    end
  endtask

  // Sender holds off until every queued result has drained.
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
  endtask

  // Decimal length field, sometimes with leading zeros.
  task automatic add_decimal(longint unsigned v);
    logic [7:0] digs[$];
    do begin
      digs.push_front(CHAR_0 + 8'(v % 10));
      v = v / 10;
    end while (v != 0);
    if ($urandom_range(0, 9) == 0)
      repeat ($urandom_range(1, 2)) digs.push_front(CHAR_0);
    foreach (digs[i]) frame_q.push_back(mk(FUNC_DATA, digs[i]));
  endtask

  // One transfer's worth of bytes. Mostly well formed with short fields;
  // a few hit the length bounds, zero lengths, a zero first name byte,
  // or get cut short. Always closes with a new connection.
  task automatic send_frame();
    int unsigned     nlen;
    int unsigned     r;
    int unsigned     n_pay;
    longint unsigned plen;
    logic [7:0]      first;
    bit              dead;
    frame_q.delete();

    r = $urandom_range(0, 99);
    if (r < 3)      nlen = 0;
    else if (r < 6) nlen = $urandom_range(MAX_NAME_LEN_DEF + 1, 999);
    else if (r < 9) nlen = MAX_NAME_LEN_DEF;
    else            nlen = $urandom_range(1, 6);
    add_decimal(nlen);
    frame_q.push_back(mk(FUNC_DATA, non_digit()));
    dead = (nlen == 0) || (nlen > MAX_NAME_LEN_DEF);

    if (!dead) begin
      first = ($urandom_range(0, 7) == 0) ? 8'h00 : 8'($urandom);
      frame_q.push_back(mk(FUNC_DATA, first));
      for (int i = 1; i < nlen; i++) frame_q.push_back(mk(FUNC_DATA, 8'($urandom)));
      dead = (first == 8'h00);
    end

    if (!dead) begin
      // separator may be any byte, a digit included
      frame_q.push_back(mk(FUNC_DATA, 8'($urandom)));
      r = $urandom_range(0, 99);
      if (r < 3)       plen = 0;
      else if (r < 6)  plen = PAY_MAX + 1 + $urandom_range(0, 3);
      else if (r < 8)  plen = PAY_MAX - $urandom_range(0, 3);
      else if (r < 10) plen = $urandom_range(32'h0001_0000, 32'h7fff_ffff);
      else if (r < 12) plen = longint'($urandom) << $urandom_range(1, 20);
      else             plen = $urandom_range(1, 12);
      add_decimal(plen);
      frame_q.push_back(mk(FUNC_DATA, non_digit()));
      if (plen != 0 && plen <= PAY_MAX) begin
        // huge lengths get a few bytes only; the frame ends unfinished
        n_pay = (plen > 24) ? $urandom_range(1, 24) : int'(plen);
        repeat (n_pay) frame_q.push_back(mk(FUNC_DATA, 8'($urandom)));
        if (plen <= 24) frame_q.push_back(mk(FUNC_DATA, 8'($urandom)));
      end
    end

    // broken transfer: truncate and maybe signal end of stream
    if ($urandom_range(0, 7) == 0) begin
      r = $urandom_range(0, frame_q.size() - 1);
      while (frame_q.size() > r) void'(frame_q.pop_back());
      if ($urandom_range(0, 1) == 1) frame_q.push_back(mk(FUNC_EOS, 8'($urandom)));
    end
    // trailing noise: any function, any byte
    if ($urandom_range(0, 4) == 0)
      repeat ($urandom_range(1, 3))
        frame_q.push_back(mk(2'($urandom_range(0, 3)), 8'($urandom)));
    frame_q.push_back(mk(FUNC_NEW, 8'($urandom)));

    foreach (frame_q[i]) send_item(frame_q[i]);
  endtask

  initial begin
    int next_drain;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_item_i   = '0;
    out_ready_i = 1'b1;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Complete transfer with extreme byte values: length 1, name 0xff,
    // payload length 2 with bytes 0x00 and 0xff, then the trailing byte.
    send_item(mk(FUNC_DATA, "1"));
    send_item(mk(FUNC_DATA, ":"));
    send_item(mk(FUNC_DATA, 8'hFF));
    send_item(mk(FUNC_DATA, "/"));
    send_item(mk(FUNC_DATA, "2"));
    send_item(mk(FUNC_DATA, " "));
    send_item(mk(FUNC_DATA, 8'h00));
    send_item(mk(FUNC_DATA, 8'hFF));
    send_item(mk(FUNC_DATA, 8'h0A));
    // finished: data and end of stream are both ignored
    send_item(mk(FUNC_DATA, 8'hAA));
    send_item(mk(FUNC_EOS, 8'h55));
    send_item(mk(FUNC_NEW, 8'h00));
    // reserved function is a no-op; then a zero name length aborts
    send_item(mk(FUNC_RSVD, 8'hFF));
    send_item(mk(FUNC_DATA, "0"));
    send_item(mk(FUNC_DATA, ":"));
    send_item(mk(FUNC_NEW, 8'hFF));
    // name length one past the bound aborts on the last digit
    send_item(mk(FUNC_DATA, "2"));
    send_item(mk(FUNC_DATA, "5"));
    send_item(mk(FUNC_DATA, "6"));
    send_item(mk(FUNC_NEW, 8'h00));
    // zero first name byte: abort on the last name byte
    send_item(mk(FUNC_DATA, "1"));
    send_item(mk(FUNC_DATA, "a"));
    send_item(mk(FUNC_DATA, 8'h00));
    send_item(mk(FUNC_NEW, 8'h00));
    // early end of stream in the name length phase
    send_item(mk(FUNC_EOS, 8'h00));
    send_item(mk(FUNC_NEW, 8'h00));
    drain();

    // Random frames; traffic shape changes from frame to frame so that
    // some stretches run with no idling at all.
    next_drain = 600;
    while (sent_count < N_ITEMS) begin
      if (sent_count >= CALM_AFTER) begin
        gap_pct   = 0;
        stall_pct = 0;
      end else begin
        case ($urandom_range(0, 2))
          0:       gap_pct = 0;
          1:       gap_pct = 8;
          default: gap_pct = 30;
        endcase
        case ($urandom_range(0, 2))
          0:       stall_pct = 0;
          1:       stall_pct = 8;
          default: stall_pct = 30;
        endcase
      end
      if (sent_count >= next_drain) begin
        drain();
        next_drain += 600;
      end
      send_frame();
    end

    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (8) @(negedge clk_i);

    if (errors == 0 && pending == 0)
      $display("length_prefixed_file_deframer_unit test passed");
    else
      $display("length_prefixed_file_deframer_unit test failed");
    $finish;
  end

endmodule

### length_prefixed_file_deframer_unit.f
src/dfr_pkg.sv
src/dfr_pipe_reg.sv
src/dfr_parser.sv
src/length_prefixed_file_deframer_unit.sv
dv/dfr_checker.sv
dv/tb_length_prefixed_file_deframer_unit.sv
